@@ design/frame_builder_bitcount_check_assert.svh @@
// Assertion macros shared by the frame builder modules.
`ifndef FRAME_BUILDER_BITCOUNT_CHECK_ASSERT_SVH
`define FRAME_BUILDER_BITCOUNT_CHECK_ASSERT_SVH

// The consequence must hold in the same cycle as the antecedent.
`define FBBC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequence must hold in the cycle after the antecedent.
`define FBBC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ design/fbbc_pkg.sv @@
// Package with the types, constants and functions of the frame builder.
`default_nettype none

package fbbc_pkg;

	localparam int unsigned S_TDATA_W = 24;

	typedef enum logic {
		REQ_START = 1'b0,
		REQ_DATA  = 1'b1
	} req_type_t;

	// Group of output bytes produced by one input item.
	typedef struct packed {
		logic [2:0]       cnt;
		logic [3:0]       ends;
		logic [3:0][7:0]  bytes;
	} fbbc_batch_t;

	function automatic logic [3:0] popcount8(input logic [7:0] b);
		logic [3:0] n;
		n = 4'd0;
		for (int k = 0; k < 8; k++) begin
			n = n + {3'd0, b[k]};
		end
		return n;
	endfunction

endpackage

`default_nettype wire

@@ design/fbbc_outbuf.sv @@
// Output buffer that hands out the bytes of one item, one transaction per cycle while m_tready is high.
`default_nettype none
`include "frame_builder_bitcount_check_assert.svh"

module fbbc_outbuf (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 load_valid,
	input  wire fbbc_pkg::fbbc_batch_t batch,
	output logic                      free,
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	output logic [7:0]                m_tdata,   // frame_byte[7:0]
	output logic                      m_tlast
);

	logic [2:0]      left_q;
	logic [1:0]      rd_q;
	logic [3:0][7:0] bytes_q;
	logic [3:0]      ends_q;
	logic            take;
	logic            load;

	assign m_tvalid = (left_q != 3'd0);
	assign take     = m_tvalid && m_tready;
	assign free     = (left_q == 3'd0) || ((left_q == 3'd1) && m_tready);
	assign load     = load_valid && free;
	assign m_tdata  = bytes_q[rd_q];
	assign m_tlast  = ends_q[rd_q] && m_tvalid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q <= 3'd0;
			rd_q   <= 2'd0;
		end else if (load) begin
			left_q <= batch.cnt;
			rd_q   <= 2'd0;
		end else if (take) begin
			left_q <= left_q - 3'd1;
			rd_q   <= rd_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			bytes_q <= batch.bytes;
			ends_q  <= batch.ends;
		end
	end

	`FBBC_ASSERT_NOW(a_load_when_free, clk, arst_n, load_valid, free, "load while busy")
	`FBBC_ASSERT_NOW(a_left_range, clk, arst_n, 1'b1, left_q <= 3'd4, "too many bytes held")
	`FBBC_ASSERT_NEXT(a_load_shows, clk, arst_n, load && (batch.cnt != 3'd0), m_tvalid && (rd_q == 2'd0), "loaded bytes not shown")

endmodule

`default_nettype wire

@@ design/frame_builder_bitcount_check.sv @@
// Top level of the frame builder with a set-bit count check.
//
// Input channel s_*: each transaction is one item. s_tuser is 0 for a start
// item (command and payload length) and 1 for a data item (one payload byte).
// Output channel m_*: each transaction is one frame byte; m_tlast marks the
// low check byte that closes a frame.
// A start item yields two header bytes, plus the two check bytes at once when
// the length is zero. A data item yields its byte, plus the two check bytes
// when it is the last payload byte. A data item with no open frame yields
// nothing, and a start item abandons any open frame.
// The input register takes each item; once the output buffer is free, the
// item's bytes are loaded into it and driven on m_* from there.
// Throughput: one input item per cycle while each item yields at most one
// byte and the receiver is ready; an item with more bytes holds the output
// buffer until its last is taken, so the output, one byte per cycle, sets the rate.
// When the receiver stalls, the buffered bytes hold and s_tready drops once
// the input register is also full. Reset clears the frame state and empties
// both the input register and the output buffer.
`default_nettype none
`include "frame_builder_bitcount_check_assert.svh"

module frame_builder_bitcount_check (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           s_tvalid,
	output logic                                s_tready,
	input  wire logic [fbbc_pkg::S_TDATA_W-1:0] s_tdata,  // command_code[3:0], payload_length[9:4], payload_byte[17:10]
	input  wire logic                           s_tuser,  // req_type[0]
	output logic                                m_tvalid,
	input  wire logic                           m_tready,
	output logic [7:0]                          m_tdata,  // frame_byte[7:0]
	output logic                                m_tlast
);

	logic        vld_s1;
	logic        type_s1;
	logic [3:0]  cmd_s1;
	logic [5:0]  len_s1;
	logic [7:0]  byte_s1;

	logic [9:0]  bit_total_q;
	logic [5:0]  bytes_left_q;
	logic        frame_open_q;

	logic [9:0]  nxt_total;
	logic [5:0]  nxt_left;
	logic        nxt_open;
	logic [7:0]  h0;
	logic [7:0]  h1;
	logic [9:0]  start_total;
	logic [9:0]  data_total;
	logic        buf_free;
	logic        advance;

	fbbc_pkg::fbbc_batch_t batch;

	assign s_tready = !vld_s1 || buf_free;
	assign advance  = vld_s1 && buf_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_tready) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			type_s1 <= s_tuser;
			cmd_s1  <= s_tdata[3:0];
			len_s1  <= s_tdata[9:4];
			byte_s1 <= s_tdata[17:10];
		end
	end

	assign h0          = {2'b00, cmd_s1, 2'b00};
	assign h1          = {1'b0, len_s1, 1'b0};
	assign start_total = {6'd0, fbbc_pkg::popcount8(h0)} + {6'd0, fbbc_pkg::popcount8(h1)};
	assign data_total  = bit_total_q + {6'd0, fbbc_pkg::popcount8(byte_s1)};

	always_comb begin
		batch     = '0;
		nxt_total = bit_total_q;
		nxt_left  = bytes_left_q;
		nxt_open  = frame_open_q;
		if (type_s1 == fbbc_pkg::REQ_START) begin
			nxt_total      = start_total;
			batch.bytes[0] = h0;
			batch.bytes[1] = h1;
			if (len_s1 == 6'd0) begin
				batch.bytes[2] = {6'd0, start_total[9:8]};
				batch.bytes[3] = start_total[7:0];
				batch.ends[3]  = 1'b1;
				batch.cnt      = 3'd4;
				nxt_open       = 1'b0;
				nxt_left       = 6'd0;
			end else begin
				batch.cnt = 3'd2;
				nxt_open  = 1'b1;
				nxt_left  = len_s1;
			end
		end else if (frame_open_q) begin
			nxt_total      = data_total;
			batch.bytes[0] = byte_s1;
			if (bytes_left_q == 6'd1) begin
				batch.bytes[1] = {6'd0, data_total[9:8]};
				batch.bytes[2] = data_total[7:0];
				batch.ends[2]  = 1'b1;
				batch.cnt      = 3'd3;
				nxt_open       = 1'b0;
				nxt_left       = 6'd0;
			end else begin
				batch.cnt = 3'd1;
				nxt_left  = bytes_left_q - 6'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_total_q  <= 10'd0;
			bytes_left_q <= 6'd0;
			frame_open_q <= 1'b0;
		end else if (advance) begin
			bit_total_q  <= nxt_total;
			bytes_left_q <= nxt_left;
			frame_open_q <= nxt_open;
		end
	end

	fbbc_outbuf u_outbuf (
		.clk        (clk),
		.arst_n     (arst_n),
		.load_valid (advance),
		.batch      (batch),
		.free       (buf_free),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast)
	);

	`FBBC_ASSERT_NOW(a_open_has_left, clk, arst_n, frame_open_q, bytes_left_q != 6'd0, "open frame with no bytes left")
	`FBBC_ASSERT_NOW(a_total_range, clk, arst_n, 1'b1, bit_total_q <= 10'd514, "bit total out of range")
	`FBBC_ASSERT_NEXT(a_drop_keeps_state, clk, arst_n, advance && (type_s1 == fbbc_pkg::REQ_DATA) && !frame_open_q, $stable(bit_total_q) && !frame_open_q, "dropped item changed state")

endmodule

`default_nettype wire
